FILE: rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

    localparam logic [31:0] HEAP_BASE = 32'hC000_0000;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_A_LOOK,
        S_A_SPLIT,
        S_A_LINK,
        S_F_LOOK,
        S_F_NEXT,
        S_F_PREV,
        S_RESP
    } t_state;

endpackage

FILE: rtl/ffha_hdr_store.sv
// Header store: synchronous memory with a registered read and the heap-start header in flops.
module ffha_hdr_store #(
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536,
    parameter int DATA_W = 38,
    parameter logic [DATA_W-1:0] RST_WORD = '0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_hdr0;
    logic [DATA_W-1:0] r_mem_q;
    logic              r_rd_zero;

    // word 0 lives in flops so reset can set it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr0 <= RST_WORD;
        end else if (i_wr_en && i_wr_addr == '0) begin
            r_hdr0 <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_addr != '0) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mem_q   <= r_mem[i_rd_addr];
            r_rd_zero <= (i_rd_addr == '0);
        end
    end

    assign o_rd_data = r_rd_zero ? r_hdr0 : r_mem_q;

endmodule

FILE: rtl/first_fit_heap_allocator.sv
// First-fit heap allocator with coalescing, sequencer around a header memory.
//
// Each request either allocates (mode 0) or frees (mode 1). The heap starts at
// byte address 0xC0000000 and is an address-ordered list of blocks, each with a
// HEADER_BYTES header kept in a one-port-read, one-port-write header memory
// indexed by byte offset / 4. An allocate rounds the size up to a multiple of 4
// and walks the list from the heap start, one header read per cycle, taking the
// first free block that fits; it splits off the remainder when that exceeds
// HEADER_BYTES + 4. Reaching the last block appends a fresh CHUNK_BYTES chunk
// while fewer than min(chunk_limit, MAX_CHUNKS) chunks are in use, else fails
// with address 0. A free walks to the block, marks it free, merges a free
// successor, then merges into a free predecessor; an unknown address gives
// success 0, a null address success 1. The header memory's single read port
// limits a walk to one list link per cycle. One request is worked on at a
// time; a finished result sits in the output register while the next request
// is accepted. No clearing pass is needed after reset.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_CHUNKS   = 4,
    parameter int CHUNK_BYTES  = 65536,
    parameter int HEADER_BYTES = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [19:0] i_request_bytes,
    input  logic [31:0] i_release_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_granted_address,
    output logic        o_success,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data
);
    localparam int OFF_W  = $clog2(MAX_CHUNKS * CHUNK_BYTES);
    localparam int WIDX_W = OFF_W - 2;
    localparam int DEPTH  = (MAX_CHUNKS * CHUNK_BYTES) / 4;
    localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
    localparam int HDR_W  = 2 * OFF_W + 2;

    typedef struct packed {
        logic [OFF_W-1:0] size;
        logic [OFF_W-1:0] next;
        logic             free;
        logic             last;
    } t_hdr;

    localparam t_hdr HDR_RST = '{
        size: OFF_W'(CHUNK_BYTES - HEADER_BYTES),
        next: '0, free: 1'b1, last: 1'b1
    };

    t_state            r_state, n_state;
    logic [31:0]       r_need, n_need;
    logic [OFF_W-1:0]  r_cur, n_cur;
    logic [31:0]       r_off, n_off;
    t_hdr              r_prev, n_prev;
    logic [OFF_W-1:0]  r_prev_off, n_prev_off;
    logic              r_prev_vld, n_prev_vld;
    t_hdr              r_blk, n_blk;
    t_hdr              r_nb, n_nb;
    logic [OFF_W-1:0]  r_nb_off, n_nb_off;
    logic [OFF_W-1:0]  r_link_off, n_link_off;
    logic [31:0]       r_res_addr, n_res_addr;
    logic              r_res_ok, n_res_ok;
    logic [CNT_W-1:0]  r_chunks, n_chunks;
    logic [2:0]        r_chunk_limit;
    logic              r_out_valid;
    logic [31:0]       r_out_addr;
    logic              r_out_ok;

    logic              rd_en;
    logic [OFF_W-1:0]  rd_off;
    logic              wr_en;
    logic [OFF_W-1:0]  wr_off;
    t_hdr              wr_hdr;
    logic [HDR_W-1:0]  rd_data;
    t_hdr              hdr;

    logic              accept;
    logic              out_free;
    logic [31:0]       lim;
    logic              a_fit, a_split, grow_ok, f_hit, f_stop;
    logic              req_zero, rel_null, rel_low;
    logic [OFF_W-1:0]  noff, coff;

    ffha_hdr_store #(
        .ADDR_W  (WIDX_W),
        .DEPTH   (DEPTH),
        .DATA_W  (HDR_W),
        .RST_WORD(HDR_RST)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_off[OFF_W-1:2]),
        .o_rd_data(rd_data),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_off[OFF_W-1:2]),
        .i_wr_data(wr_hdr)
    );

    assign hdr        = t_hdr'(rd_data);
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // effective growth limit
    assign lim = (32'(r_chunk_limit) > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS)
                                                         : 32'(r_chunk_limit);

    assign req_zero = (i_request_bytes == '0);
    assign rel_null = (i_release_address == '0);
    assign rel_low  = (i_release_address < HEAP_BASE + 32'(HEADER_BYTES));

    assign a_fit   = hdr.free && (32'(hdr.size) >= r_need);
    assign a_split = 32'(hdr.size) > r_need + 32'(HEADER_BYTES) + 32'd4;
    assign grow_ok = 32'(r_chunks) < lim;
    assign noff    = OFF_W'(32'(r_cur) + 32'(HEADER_BYTES) + r_need);
    assign coff    = OFF_W'(32'(r_chunks) * 32'(CHUNK_BYTES));
    assign f_hit   = (32'(r_cur) == r_off);
    assign f_stop  = hdr.last || (32'(r_cur) > r_off);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_mode == MODE_ALLOC) begin
                        n_state = req_zero ? S_RESP : S_A_LOOK;
                    end else begin
                        n_state = (rel_null || rel_low) ? S_RESP : S_F_LOOK;
                    end
                end
            end
            S_A_LOOK: begin
                if (a_fit) begin
                    n_state = a_split ? S_A_SPLIT : S_RESP;
                end else if (hdr.last) begin
                    n_state = grow_ok ? S_A_LINK : S_RESP;
                end
            end
            S_A_SPLIT: n_state = S_RESP;
            S_A_LINK:  n_state = S_A_LOOK;
            S_F_LOOK: begin
                if (f_hit) begin
                    n_state = hdr.last ? S_F_PREV : S_F_NEXT;
                end else if (f_stop) begin
                    n_state = S_RESP;
                end
            end
            S_F_NEXT: n_state = S_F_PREV;
            S_F_PREV: n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory port control
    always_comb begin
        n_need     = r_need;
        n_cur      = r_cur;
        n_off      = r_off;
        n_prev     = r_prev;
        n_prev_off = r_prev_off;
        n_prev_vld = r_prev_vld;
        n_blk      = r_blk;
        n_nb       = r_nb;
        n_nb_off   = r_nb_off;
        n_link_off = r_link_off;
        n_res_addr = r_res_addr;
        n_res_ok   = r_res_ok;
        n_chunks   = r_chunks;
        rd_en      = 1'b0;
        rd_off     = '0;
        wr_en      = 1'b0;
        wr_off     = r_cur;
        wr_hdr     = r_blk;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_need     = (32'(i_request_bytes) + 32'd3) & ~32'd3;
                    n_off      = i_release_address - HEAP_BASE - 32'(HEADER_BYTES);
                    n_cur      = '0;
                    n_prev_vld = 1'b0;
                    n_res_addr = '0;
                    n_res_ok   = (i_mode == MODE_FREE) && rel_null;
                    rd_en      = 1'b1;
                end
            end
            S_A_LOOK: begin
                if (a_fit) begin
                    // take the block; keep the split-off remainder for next cycle
                    wr_en       = 1'b1;
                    wr_off      = r_cur;
                    wr_hdr.size = a_split ? OFF_W'(r_need) : hdr.size;
                    wr_hdr.next = a_split ? noff : hdr.next;
                    wr_hdr.last = a_split ? 1'b0 : hdr.last;
                    wr_hdr.free = 1'b0;
                    n_nb.size   = OFF_W'(32'(hdr.size) - r_need - 32'(HEADER_BYTES));
                    n_nb.next   = hdr.next;
                    n_nb.free   = 1'b1;
                    n_nb.last   = hdr.last;
                    n_nb_off    = noff;
                    n_res_addr  = HEAP_BASE + 32'(r_cur) + 32'(HEADER_BYTES);
                    n_res_ok    = 1'b1;
                end else if (hdr.last) begin
                    if (grow_ok) begin
                        // lay down the new chunk header, link it next cycle
                        wr_en       = 1'b1;
                        wr_off      = coff;
                        wr_hdr.size = OFF_W'(CHUNK_BYTES - HEADER_BYTES);
                        wr_hdr.next = '0;
                        wr_hdr.free = 1'b1;
                        wr_hdr.last = 1'b1;
                        n_link_off  = coff;
                        n_blk       = hdr;
                    end else begin
                        n_res_addr = '0;
                        n_res_ok   = 1'b0;
                    end
                end else begin
                    n_cur  = hdr.next;
                    rd_en  = 1'b1;
                    rd_off = hdr.next;
                end
            end
            S_A_SPLIT: begin
                wr_en  = 1'b1;
                wr_off = r_nb_off;
                wr_hdr = r_nb;
            end
            S_A_LINK: begin
                wr_en       = 1'b1;
                wr_off      = r_cur;
                wr_hdr      = r_blk;
                wr_hdr.next = r_link_off;
                wr_hdr.last = 1'b0;
                n_chunks    = r_chunks + CNT_W'(1);
                n_cur       = r_link_off;
                rd_en       = 1'b1;
                rd_off      = r_link_off;
            end
            S_F_LOOK: begin
                if (f_hit) begin
                    n_blk      = hdr;
                    n_blk.free = 1'b1;
                    if (hdr.last) begin
                        wr_en       = 1'b1;
                        wr_off      = r_cur;
                        wr_hdr      = hdr;
                        wr_hdr.free = 1'b1;
                    end else begin
                        rd_en  = 1'b1;
                        rd_off = hdr.next;
                    end
                end else if (f_stop) begin
                    n_res_addr = '0;
                    n_res_ok   = 1'b0;
                end else begin
                    n_prev     = hdr;
                    n_prev_off = r_cur;
                    n_prev_vld = 1'b1;
                    n_cur      = hdr.next;
                    rd_en      = 1'b1;
                    rd_off     = hdr.next;
                end
            end
            S_F_NEXT: begin
                // absorb a free successor
                if (hdr.free) begin
                    n_blk.size = OFF_W'(32'(r_blk.size) + 32'(HEADER_BYTES)
                                        + 32'(hdr.size));
                    n_blk.next = hdr.next;
                    n_blk.last = hdr.last;
                end
                wr_en  = 1'b1;
                wr_off = r_cur;
                wr_hdr = n_blk;
            end
            S_F_PREV: begin
                // fold into a free predecessor
                if (r_prev_vld && r_prev.free) begin
                    wr_en       = 1'b1;
                    wr_off      = r_prev_off;
                    wr_hdr.size = OFF_W'(32'(r_prev.size) + 32'(HEADER_BYTES)
                                         + 32'(r_blk.size));
                    wr_hdr.next = r_blk.next;
                    wr_hdr.free = r_prev.free;
                    wr_hdr.last = r_blk.last;
                end
                n_res_addr = '0;
                n_res_ok   = 1'b1;
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_chunks      <= CNT_W'(1);
            r_chunk_limit <= 3'd4;
            r_out_valid   <= 1'b0;
            r_prev_vld    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_chunks   <= n_chunks;
            r_prev_vld <= n_prev_vld;
            if (i_cfg_we) begin
                r_chunk_limit <= i_cfg_data;
            end
            // hold the result until taken, load when the slot frees
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_need     <= n_need;
        r_cur      <= n_cur;
        r_off      <= n_off;
        r_prev     <= n_prev;
        r_prev_off <= n_prev_off;
        r_blk      <= n_blk;
        r_nb       <= n_nb;
        r_nb_off   <= n_nb_off;
        r_link_off <= n_link_off;
        r_res_addr <= n_res_addr;
        r_res_ok   <= n_res_ok;
        if (r_state == S_RESP && out_free) begin
            r_out_addr <= r_res_addr;
            r_out_ok   <= r_res_ok;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_granted_address = r_out_addr;
    assign o_success         = r_out_ok;

    // heap never shrinks below one chunk nor grows past the cap
    a_chunk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunks >= CNT_W'(1) && 32'(r_chunks) <= 32'(MAX_CHUNKS))
        else $error("chunk count out of range");

    // chunks are only added in the link step
    a_chunk_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_A_LINK |=> $stable(r_chunks))
        else $error("chunk count changed outside link step");

    // a nonzero address is only ever reported with success
    a_addr_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted_address != '0 |-> o_success)
        else $error("address returned on failure");

    // no request taken while a walk is in flight
    a_one_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_in_stall)
        else $error("request accepted while busy");

endmodule
